/* design/mtc_pkg.sv */
// package: constants, state and token kind codes, result record types
package mtc_pkg;

  // longest token the length counter follows before it sticks
  localparam int MAX_TOKEN_LENGTH = 4095;
  localparam int CNT_W            = $clog2(MAX_TOKEN_LENGTH + 1);

  // width of the reported token length
  localparam int TOKEN_LEN_W   = 12;
  localparam int TOKEN_LEN_MAX = (2 ** TOKEN_LEN_W) - 1;
  localparam int LEN_EXT_W     = (CNT_W > TOKEN_LEN_W) ? CNT_W : TOKEN_LEN_W;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // characters that steer the recognizer
  localparam logic [7:0] CH_LT = 8'h3C;  // <
  localparam logic [7:0] CH_PC = 8'h25;  // %
  localparam logic [7:0] CH_GT = 8'h3E;  // >
  localparam logic [7:0] CH_HS = 8'h23;  // #
  localparam logic [7:0] CH_AT = 8'h40;  // @
  localparam logic [7:0] CH_LB = 8'h5B;  // [
  localparam logic [7:0] CH_RB = 8'h5D;  // ]
  localparam logic [7:0] CH_EQ = 8'h3D;  // =
  localparam logic [7:0] CH_NL = 8'h0A;  // newline

  typedef enum logic [2:0] {
    KIND_END    = 3'd0,
    KIND_PASS   = 3'd1,
    KIND_MSTART = 3'd2,
    KIND_MREF   = 3'd3,
    KIND_MEND   = 3'd4,
    KIND_TSUB   = 3'd5,
    KIND_DIR    = 3'd6
  } kind_t;

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_ME1  = 19'h00002,
    S_ME2  = 19'h00004,
    S_ME3  = 19'h00008,
    S_ME4  = 19'h00010,
    S_MS1  = 19'h00020,
    S_MS2  = 19'h00040,
    S_MS3  = 19'h00080,
    S_MS4  = 19'h00100,
    S_MS5  = 19'h00200,
    S_TS1  = 19'h00400,
    S_TS2  = 19'h00800,
    S_TS3  = 19'h01000,
    S_TS4  = 19'h02000,
    S_SD1  = 19'h04000,
    S_SD2  = 19'h08000,
    S_SD3  = 19'h10000,
    S_SD4  = 19'h20000,
    S_SD5  = 19'h40000
  } state_t;

  typedef struct packed {
    kind_t                   kind;
    logic [TOKEN_LEN_W-1:0]  length;
    logic                    saturated;
    logic                    last;
  } result_t;

  // results produced by one accepted character, first in first position
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

/* design/mtc_if.sv */
// channel interfaces: character input and token result output
interface mtc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;

  modport source (output valid, output char_byte, output end_of_input, input ready);
  modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface mtc_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [11:0] token_length;
  logic        length_saturated;
  logic        last_result;

  modport source (output valid, output token_kind, output token_length,
                  output length_saturated, output last_result, input ready);
  modport sink   (input valid, input token_kind, input token_length,
                  input length_saturated, input last_result, output ready);
endinterface

/* design/mtc_recognizer.sv */
// recognizer state, token length counter and per-character result generation
module mtc_recognizer
  import mtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_byte,
  input  logic       end_of_input,
  output push_t      push
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             ovf, ovf_next;

  logic [CNT_W-1:0] take_cnt;
  logic             take_ovf;
  state_t           idle_st;
  logic             do_adv, do_fail, do_fin, do_look;
  state_t           adv_st;
  kind_t            fin_kind;
  push_t            push_raw;

  function automatic result_t make_res(kind_t k, logic [CNT_W-1:0] n, logic o);
    result_t              r;
    logic [LEN_EXT_W-1:0] ext;
    ext = LEN_EXT_W'(n);
    r.kind = k;
    r.last = 1'b0;
    if (ext > LEN_EXT_W'(TOKEN_LEN_MAX)) begin
      r.length    = TOKEN_LEN_W'(TOKEN_LEN_MAX);
      r.saturated = 1'b1;
    end else begin
      r.length    = ext[TOKEN_LEN_W-1:0];
      r.saturated = o;
    end
    return r;
  endfunction

  // length after taking one more character
  always_comb begin
    take_cnt = cnt;
    take_ovf = ovf;
    if (cnt < CNT_W'(MAX_TOKEN_LENGTH)) begin
      take_cnt = cnt + 1'b1;
    end else begin
      take_ovf = 1'b1;
    end
  end

  // token openers seen from idle
  always_comb begin
    case (char_byte)
      CH_LT:   idle_st = S_MS1;
      CH_PC:   idle_st = S_TS1;
      CH_GT:   idle_st = S_ME1;
      CH_HS:   idle_st = S_SD1;
      default: idle_st = S_IDLE;
    endcase
  end

  // pattern step: advance, fail, finish or restart from idle
  always_comb begin
    do_adv   = 1'b0;
    do_fail  = 1'b0;
    do_fin   = 1'b0;
    do_look  = 1'b0;
    adv_st   = state;
    fin_kind = KIND_PASS;
    case (state)
      S_ME1: if (char_byte == CH_GT) begin do_adv = 1'b1; adv_st = S_ME2; end
             else do_fail = 1'b1;
      S_ME2: if (char_byte == CH_AT) begin do_adv = 1'b1; adv_st = S_ME3; end
             else do_fail = 1'b1;
      S_ME3: if (char_byte == CH_LT) begin do_adv = 1'b1; adv_st = S_ME4; end
             else do_fail = 1'b1;
      S_ME4: if (char_byte == CH_LT) begin do_fin = 1'b1; fin_kind = KIND_MEND; end
             else do_fail = 1'b1;
      S_MS1: if (char_byte == CH_LT) begin do_adv = 1'b1; adv_st = S_MS2; end
             else do_fail = 1'b1;
      S_MS2: if (char_byte != CH_GT) begin do_adv = 1'b1; adv_st = S_MS3; end
             else do_fail = 1'b1;
      S_MS3: begin
        if (char_byte == CH_GT) begin
          do_adv = 1'b1;
          adv_st = S_MS4;
        end else if (char_byte == CH_NL) begin
          do_fail = 1'b1;
        end else begin
          do_adv = 1'b1;
          adv_st = S_MS3;
        end
      end
      S_MS4: if (char_byte == CH_GT) begin do_adv = 1'b1; adv_st = S_MS5; end
             else do_fail = 1'b1;
      S_MS5: if (char_byte == CH_EQ) begin do_fin = 1'b1; fin_kind = KIND_MSTART; end
             else do_look = 1'b1;
      S_TS1: if (char_byte == CH_LB) begin do_adv = 1'b1; adv_st = S_TS2; end
             else do_fail = 1'b1;
      S_TS2: if (char_byte != CH_RB) begin do_adv = 1'b1; adv_st = S_TS3; end
             else do_fail = 1'b1;
      S_TS3: begin
        do_adv = 1'b1;
        adv_st = (char_byte == CH_RB) ? S_TS4 : S_TS3;
      end
      S_TS4: if (char_byte == CH_PC) begin do_fin = 1'b1; fin_kind = KIND_TSUB; end
             else do_fail = 1'b1;
      S_SD1: if (char_byte == CH_LB) begin do_adv = 1'b1; adv_st = S_SD2; end
             else do_fail = 1'b1;
      S_SD2: if (char_byte != CH_EQ) begin do_adv = 1'b1; adv_st = S_SD3; end
             else do_fail = 1'b1;
      S_SD3: begin
        do_adv = 1'b1;
        adv_st = (char_byte == CH_EQ) ? S_SD4 : S_SD3;
      end
      S_SD4: if (char_byte != CH_RB) begin do_adv = 1'b1; adv_st = S_SD5; end
             else do_fail = 1'b1;
      S_SD5: if (char_byte == CH_RB) begin do_fin = 1'b1; fin_kind = KIND_DIR; end
             else begin do_adv = 1'b1; adv_st = S_SD5; end
      default: do_look = 1'b1;
    endcase
  end

  // results and next state for this character
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    ovf_next        = ovf;
    push_raw.count  = 2'd0;
    push_raw.first  = make_res(KIND_END, '0, 1'b0);
    push_raw.second = make_res(KIND_END, '0, 1'b0);
    if (end_of_input) begin
      state_next = S_IDLE;
      cnt_next   = '0;
      ovf_next   = 1'b0;
      if (state == S_IDLE) begin
        push_raw.count = 2'd1;
      end else begin
        push_raw.count = 2'd2;
        push_raw.first = make_res((state == S_MS5) ? KIND_MREF : KIND_PASS, cnt, ovf);
      end
    end else if (do_adv) begin
      state_next = adv_st;
      cnt_next   = take_cnt;
      ovf_next   = take_ovf;
    end else if (do_fail || do_fin) begin
      state_next     = S_IDLE;
      cnt_next       = '0;
      ovf_next       = 1'b0;
      push_raw.count = 2'd1;
      push_raw.first = make_res(do_fin ? fin_kind : KIND_PASS, take_cnt, take_ovf);
    end else if (do_look) begin
      // a pending macro reference closes before the lookahead is handled
      if (state == S_MS5) begin
        push_raw.count = 2'd1;
        push_raw.first = make_res(KIND_MREF, cnt, ovf);
      end
      if (idle_st != S_IDLE) begin
        state_next = idle_st;
        cnt_next   = CNT_W'(1);
        ovf_next   = 1'b0;
      end else begin
        state_next = S_IDLE;
        cnt_next   = '0;
        ovf_next   = 1'b0;
        if (state == S_MS5) begin
          push_raw.count  = 2'd2;
          push_raw.second = make_res(KIND_PASS, CNT_W'(1), 1'b0);
        end else begin
          push_raw.count = 2'd1;
          push_raw.first = make_res(KIND_PASS, CNT_W'(1), 1'b0);
        end
      end
    end
  end

  // mark the final result of the transaction; no results are pushed unless a character is accepted
  always_comb begin
    push = push_raw;
    if (!accept) begin
      push.count = 2'd0;
    end
    push.first.last  = (push_raw.count == 2'd1);
    push.second.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      ovf   <= 1'b0;
    end else if (accept) begin
      state <= state_next;
      cnt   <= cnt_next;
      ovf   <= ovf_next;
    end
  end

endmodule

/* design/mtc_result_fifo.sv */
// result queue: takes up to two results a cycle, hands out one
module mtc_result_fifo
  import mtc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  logic    pop,
  output result_t head,
  output logic    head_valid,
  output logic    has_room
);

  result_t              entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_AW:0]     count;
  logic                 do_pop;

  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;
  // room for the two results that one character may cause
  assign has_room   = (count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));

  // storage writes
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + 1'b1] <= push.second;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (FIFO_AW + 1)'(push.count) - (FIFO_AW + 1)'(do_pop);
    end
  end

endmodule

/* design/markup_token_classifier.sv */
// top level: markup token classifier with character input and token output channels

// Takes one character (or an end-of-input mark) per transaction and can accept
// one in every clock cycle. Each character gives zero, one or two token results;
// they are stored in the result queue when the character is accepted and leave
// it on the output channel, one result per output transaction, the last one of
// a character flagged by last_result. Results wait in a four-entry queue; the
// input is ready while the queue has room for two, so a character that closes
// two tokens takes two output transactions, and sustained input rate is one
// character a cycle while results are taken as fast as they are produced.
module markup_token_classifier
  import mtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  mtc_char_if.sink           chars,
  mtc_token_if.source        tokens
);

  logic    accept;
  push_t   push;
  result_t head;
  logic    head_valid;
  logic    has_room;

  assign chars.ready = has_room;
  assign accept      = chars.valid && has_room;

  // recognizer
  mtc_recognizer u_recognizer (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_byte    (chars.char_byte),
    .end_of_input (chars.end_of_input),
    .push         (push)
  );

  // result queue
  mtc_result_fifo u_result_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (tokens.ready),
    .head       (head),
    .head_valid (head_valid),
    .has_room   (has_room)
  );

  // output channel
  assign tokens.valid            = head_valid;
  assign tokens.token_kind       = head.kind;
  assign tokens.token_length     = head.length;
  assign tokens.length_saturated = head.saturated;
  assign tokens.last_result      = head.last;

endmodule
